// ===== rtl/tdf_pkg.sv =====
// Shared types and constants for the trial division factorizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tdf_pkg;

  // fixed widths of the stream fields
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FACTOR_W = 32;

  // default width of the value that is factored
  localparam int unsigned VALUE_BITS_DEF = 32;

  // at most this many factors per request
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS);

  // first trial divisor
  localparam int unsigned FIRST_DIVISOR = 2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIVIAL,
    S_START,
    S_DIV,
    S_CHECK
  } state_e;

  // one result on its way to the output register
  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic                last;
    logic                no_factors;
  } res_t;

endpackage

// ===== rtl/tdf_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Uses tdf_pkg; instantiated by trial_division_factorizer_core.
`timescale 1ns / 1ps

module tdf_divider #(
  parameter int unsigned RemW = 32,
  parameter int unsigned DivW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RemW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            busy_o,
  output logic [RemW-1:0] quotient_o,
  output logic            rem_zero_o
);
  import tdf_pkg::*;

  localparam int unsigned CntW = $clog2(RemW + 1);

  logic            run_q, run_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RemW-1:0] quo_q, quo_d;
  logic [DivW-1:0] part_q, part_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            fits;

  // one restoring step: bring down the next dividend bit and try to subtract
  always_comb begin
    trial = {part_q, quo_q[RemW-1]};
    fits  = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
  end

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    part_d = part_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CntW'(RemW);
      quo_d  = dividend_i;
      part_d = '0;
      dvs_d  = divisor_i;
    end else if (run_q) begin
      quo_d  = {quo_q[RemW-2:0], fits};
      part_d = fits ? diff[DivW-1:0] : trial[DivW-1:0];
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  // registers for quotient, partial remainder and divisor
  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    part_q <= part_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o     = run_q;
  assign quotient_o = quo_q;
  assign rem_zero_o = (part_q == '0);

endmodule

// ===== rtl/tdf_out_buf.sv =====
// Output register between the sequencer and the result stream.
// Uses tdf_pkg for the result type.
`timescale 1ns / 1ps

module tdf_out_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  tdf_pkg::res_t                 push_data_i,
  output logic                          ready_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tdf_pkg::FACTOR_W-1:0]  m_axis_tdata_o,  // [31:0] factor
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tuser_o   // [0] no_factors
);
  import tdf_pkg::*;

  logic valid_q, valid_d;
  res_t data_q, data_d;

  // free when empty or when the held request leaves this cycle
  assign ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (push_i && ready_o) begin
      valid_d = 1'b1;
      data_d  = push_data_i;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q.factor;
  assign m_axis_tlast_o  = data_q.last;
  assign m_axis_tuser_o  = data_q.no_factors;

endmodule

// ===== rtl/trial_division_factorizer_core.sv =====
// Trial division factorizer: each trial divisor passes through S_START (divider start),
// the bit-serial divider run, S_DIV seeing it done and an S_CHECK decision.
// An input n needs about sqrt(n) + number of factors trial divisions;
// a prime near 2^32 needs about 65536 trials. Inputs 0 and 1 skip the divider
// and are reported with no_factors set. One request is factored at a time.
// Reset (rst_ni low, asynchronous) empties the output register and returns to idle.
// Depends on tdf_pkg, tdf_divider and tdf_out_buf.
`timescale 1ns / 1ps

module trial_division_factorizer_core #(
  parameter int unsigned VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tdf_pkg::VALUE_W-1:0]   s_axis_tdata_i,   // [31:0] value
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tdf_pkg::FACTOR_W-1:0]  m_axis_tdata_o,   // [31:0] factor
  output logic                          m_axis_tlast_o,   // last
  output logic                          m_axis_tuser_o    // [0] no_factors
);
  import tdf_pkg::*;

  localparam int unsigned RemW = VALUE_BITS;
  localparam int unsigned DivW = (VALUE_BITS + 1) / 2 + 1;

  state_e           state_q, state_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [RemW-1:0]  value_in;
  logic             div_start;
  logic             div_busy;
  logic [RemW-1:0]  div_quo;
  logic             div_rem_zero;
  logic             push;
  res_t             push_data;
  logic             buf_ready;
  logic             stop;

  assign value_in = RemW'(s_axis_tdata_i);

  // loop ends once divisor exceeds remaining / divisor or the result budget is used
  assign stop = (RemW'(dvs_q) > div_quo) || (cnt_q == CNT_W'(MAX_RESULTS - 1));

  // sequencer
  always_comb begin
    state_d         = state_q;
    rem_d           = rem_q;
    dvs_d           = dvs_q;
    cnt_d           = cnt_q;
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    push            = 1'b0;
    push_data       = '0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          rem_d = value_in;
          dvs_d = DivW'(FIRST_DIVISOR);
          cnt_d = '0;
          if (value_in <= RemW'(1)) begin
            state_d = S_TRIVIAL;
          end else begin
            state_d = S_START;
          end
        end
      end
      S_TRIVIAL: begin
        push      = 1'b1;
        push_data = '{factor: FACTOR_W'(rem_q), last: 1'b1, no_factors: 1'b1};
        if (buf_ready) begin
          state_d = S_IDLE;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stop) begin
          // leftover above one is the final prime factor
          if (rem_q > RemW'(1)) begin
            push      = 1'b1;
            push_data = '{factor: FACTOR_W'(rem_q), last: 1'b1, no_factors: 1'b0};
            if (buf_ready) begin
              state_d = S_IDLE;
            end
          end else begin
            state_d = S_IDLE;
          end
        end else if (div_rem_zero) begin
          // divisor divides: it is the last factor when the quotient is one
          push      = 1'b1;
          push_data = '{factor: FACTOR_W'(dvs_q), last: (div_quo == RemW'(1)),
                        no_factors: 1'b0};
          if (buf_ready) begin
            rem_d   = div_quo;
            cnt_d   = cnt_q + CNT_W'(1);
            state_d = S_START;
          end
        end else begin
          dvs_d   = dvs_q + DivW'(1);
          state_d = S_START;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= '0;
      dvs_q   <= DivW'(FIRST_DIVISOR);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      dvs_q   <= dvs_d;
      cnt_q   <= cnt_d;
    end
  end

  // serial divider for remaining / divisor
  tdf_divider #(
    .RemW (RemW),
    .DivW (DivW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (dvs_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo),
    .rem_zero_o (div_rem_zero)
  );

  // result register toward the output stream
  tdf_out_buf u_out_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .push_data_i     (push_data),
    .ready_o         (buf_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
